>>> design/rclt_pkg.sv
// Shared types and constants for the remote code learning table.
// Used by the core, its result stage, its RAMs and its checker.
package rclt_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int MAX_OUT   = 8;
	localparam int HCNT_W    = $clog2(MAX_OUT + 1);

	localparam int CMD_W   = 3;
	localparam int CODE_W  = 32;
	localparam int SLOT_W  = 8;
	localparam int MODE_W  = 2;
	localparam int BTN_W   = 8;
	localparam int KIND_W  = 3;
	localparam int HIT_W   = 6;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int CFGI_W  = 1;

	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RECV   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ADD    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd4;

	localparam logic [KIND_W-1:0] KIND_ACK      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BUTTON   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LEARNED  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SUPPRESS = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NOMATCH  = 3'd4;

	localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ERASED = 2'd3;

	localparam logic [CFGI_W-1:0] REG_REPEAT_TIME  = 1'b0;
	localparam logic [CFGI_W-1:0] REG_LEARN_WINDOW = 1'b1;

	localparam logic [BTN_W-1:0] NO_BUTTON    = 8'hFF;
	localparam logic [CFG_W-1:0] REPEAT_RESET = 16'd500;
	localparam logic [CFG_W-1:0] LEARN_RESET  = 16'd5000;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              ok;
		logic [BTN_W-1:0]  button;
		logic [HIT_W-1:0]  hit_slot;
	} res_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_HIT,
		EMIT_FINISH,
		EMIT_DIRECT
	} emit_op_t;

	typedef struct packed {
		emit_op_t op;
		res_t     res;
	} emit_t;

endpackage

>>> design/rclt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on rclt_pkg for default sizes only.
module rclt_ram #(
	parameter int WIDTH = rclt_pkg::BTN_W,
	parameter int DEPTH = rclt_pkg::SLOTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/rclt_result.sv
// Result stage: holds the newest hit back until the next one or the end of the scan
// sets its last flag, caps reported hits, and drives the output register. Uses rclt_pkg.
module rclt_result (
	input  logic          clk,
	input  logic          arst_n,
	input  rclt_pkg::emit_t req,
	output logic          free,
	output logic          out_valid,
	input  logic          out_ready,
	output rclt_pkg::res_t res,
	output logic          last
);

	import rclt_pkg::*;

	logic              out_valid_q;
	res_t              out_q;
	logic              last_q;
	logic              pend_v_q;
	res_t              pend_q;
	logic [HCNT_W-1:0] cnt_q;
	res_t              nomatch;

	assign nomatch   = '{kind: KIND_NOMATCH, ok: 1'b1, button: '0, hit_slot: '0};
	assign free      = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign res       = out_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
			last_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_q      <= '0;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (req.op)
				EMIT_HIT: begin
					if (cnt_q < HCNT_W'(MAX_OUT)) begin
						if (pend_v_q) begin
							out_q       <= pend_q;
							last_q      <= 1'b0;
							out_valid_q <= 1'b1;
						end
						pend_q   <= req.res;
						pend_v_q <= 1'b1;
						cnt_q    <= cnt_q + 1'b1;
					end
				end
				EMIT_FINISH: begin
					out_q       <= pend_v_q ? pend_q : nomatch;
					last_q      <= 1'b1;
					out_valid_q <= 1'b1;
					pend_v_q    <= 1'b0;
					cnt_q       <= '0;
				end
				EMIT_DIRECT: begin
					out_q       <= req.res;
					last_q      <= 1'b1;
					out_valid_q <= 1'b1;
					pend_v_q    <= 1'b0;
					cnt_q       <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> design/remote_code_learning_table_core.sv
// Remote code learning table. Add, remove and load are acknowledged; tick gives no output.
// Received code: suppressed, learned, or matched one slot per cycle while the result stage is
// free (through the code RAM read port and one comparator); one item at a time.
// Asynchronous reset clears modes, written flags, the clock, timers and the config registers
// (500, 5000); RAM contents are left alone, unwritten entries read as code 0, button 0xFF.
module remote_code_learning_table_core #(
	parameter int SLOTS = rclt_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rclt_pkg::CMD_W-1:0]    cmd,
	input  logic [rclt_pkg::CODE_W-1:0]   code,
	input  logic [rclt_pkg::SLOT_W-1:0]   slot,
	input  logic [rclt_pkg::MODE_W-1:0]   load_state,
	input  logic [rclt_pkg::BTN_W-1:0]    load_button,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rclt_pkg::KIND_W-1:0]   kind,
	output logic                          ok,
	output logic [rclt_pkg::BTN_W-1:0]    button,
	output logic [rclt_pkg::HIT_W-1:0]    hit_slot,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rclt_pkg::CFGI_W-1:0]   cfg_index,
	input  logic [rclt_pkg::CFG_W-1:0]    cfg_data
);

	import rclt_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DECIDE,
		ST_LEARN,
		ST_MATCH,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [CODE_W-1:0]  code_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [MODE_W-1:0]  lstate_q;
	logic [BTN_W-1:0]   lbutton_q;
	logic [MODE_W-1:0]  mode_q [SLOTS];
	logic [SLOTS-1:0]   code_wr_q;
	logic [SLOTS-1:0]   btn_wr_q;
	logic               armed_q;
	logic [TIME_W-1:0]  last_ev_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic [CFG_W-1:0]   rt_q;
	logic [CFG_W-1:0]   lw_q;
	logic [CNT_W-1:0]   scan_q;
	logic               cmp_v_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;
	logic               code_vld_s1;
	logic               btn_vld_s1;

	logic               free;
	emit_t              req;
	res_t               res_o;
	logic [IDX_W-1:0]   idx_scan;
	logic [IDX_W-1:0]   slot_idx;
	logic               slot_ok;
	logic               scan_end;
	logic               in_learn;
	logic               in_repeat;
	logic               learn_hit;
	logic               match_hit;
	logic               ack_ok;
	logic               code_we;
	logic [IDX_W-1:0]   code_waddr;
	logic               btn_we;
	logic               rd_re;
	logic [CODE_W-1:0]  code_rdata;
	logic [BTN_W-1:0]   btn_rdata;
	logic [CODE_W-1:0]  code_rd;
	logic [BTN_W-1:0]   btn_rd;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	assign idx_scan  = scan_q[IDX_W-1:0];
	assign slot_idx  = slot_q[IDX_W-1:0];
	assign slot_ok   = {1'b0, slot_q} < (SLOT_W + 1)'(SLOTS);
	assign scan_end  = (scan_q == CNT_W'(SLOTS));
	assign in_learn  = elapsed_q < {{(TIME_W - CFG_W){1'b0}}, lw_q};
	assign in_repeat = elapsed_q < {{(TIME_W - CFG_W){1'b0}}, rt_q};
	assign learn_hit = !scan_end && (mode_q[idx_scan] == MODE_WAIT);
	assign code_rd   = code_vld_s1 ? code_rdata : '0;
	assign btn_rd    = btn_vld_s1 ? btn_rdata : NO_BUTTON;
	assign match_hit = cmp_v_s1 && (mode_q[cmp_idx_s1] == MODE_ACTIVE) && (code_rd == code_q);
	assign ack_ok    = slot_ok &&
		(cmd_q == CMD_ADD || cmd_q == CMD_REMOVE || cmd_q == CMD_LOAD);

	always_comb begin
		req.op     = EMIT_NONE;
		req.res    = '0;
		code_we    = 1'b0;
		code_waddr = slot_idx;
		btn_we     = 1'b0;
		rd_re      = 1'b0;
		unique case (state_q)
			ST_EXEC: begin
				if (free && cmd_q != CMD_TICK && cmd_q != CMD_RECV) begin
					req.op     = EMIT_DIRECT;
					req.res.kind = KIND_ACK;
					req.res.ok = ack_ok;
					if (cmd_q == CMD_LOAD && slot_ok) begin
						code_we = 1'b1;
						btn_we  = 1'b1;
					end
				end
			end
			ST_DECIDE: begin
				if (free && !(armed_q && in_learn) && in_repeat) begin
					req.op       = EMIT_DIRECT;
					req.res.kind = KIND_SUPPRESS;
					req.res.ok   = 1'b1;
				end
			end
			ST_LEARN: begin
				if (free && learn_hit) begin
					code_we          = 1'b1;
					code_waddr       = idx_scan;
					req.op           = EMIT_HIT;
					req.res.kind     = KIND_LEARNED;
					req.res.ok       = 1'b1;
					req.res.hit_slot = HIT_W'(idx_scan);
				end
			end
			ST_MATCH: begin
				if (free) begin
					rd_re = !scan_end;
					if (match_hit) begin
						req.op           = EMIT_HIT;
						req.res.kind     = KIND_BUTTON;
						req.res.ok       = 1'b1;
						req.res.button   = btn_rd;
						req.res.hit_slot = HIT_W'(cmp_idx_s1);
					end
				end
			end
			ST_FINISH: begin
				if (free) begin
					req.op = EMIT_FINISH;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			code_q      <= '0;
			slot_q      <= '0;
			lstate_q    <= '0;
			lbutton_q   <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				mode_q[i] <= MODE_OFF;
			end
			code_wr_q   <= '0;
			btn_wr_q    <= '0;
			armed_q     <= 1'b0;
			last_ev_q   <= '0;
			now_q       <= '0;
			elapsed_q   <= '0;
			rt_q        <= REPEAT_RESET;
			lw_q        <= LEARN_RESET;
			scan_q      <= '0;
			cmp_v_s1    <= 1'b0;
			cmp_idx_s1  <= '0;
			code_vld_s1 <= 1'b0;
			btn_vld_s1  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_REPEAT_TIME:  rt_q <= cfg_data;
					REG_LEARN_WINDOW: lw_q <= cfg_data;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q     <= cmd;
						code_q    <= code;
						slot_q    <= slot;
						lstate_q  <= load_state;
						lbutton_q <= load_button;
						state_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd_q == CMD_TICK) begin
						now_q   <= now_q + 1'b1;
						state_q <= ST_IDLE;
					end else if (cmd_q == CMD_RECV) begin
						elapsed_q <= now_q - last_ev_q;
						state_q   <= ST_DECIDE;
					end else if (free) begin
						if (slot_ok) begin
							if (cmd_q == CMD_ADD) begin
								mode_q[slot_idx] <= MODE_WAIT;
								armed_q          <= 1'b1;
								last_ev_q        <= now_q;
							end else if (cmd_q == CMD_REMOVE) begin
								mode_q[slot_idx]    <= MODE_OFF;
								code_wr_q[slot_idx] <= 1'b0;
								btn_wr_q[slot_idx]  <= 1'b0;
							end else if (cmd_q == CMD_LOAD) begin
								mode_q[slot_idx]    <= (lstate_q == MODE_ERASED) ? MODE_OFF
									: lstate_q;
								code_wr_q[slot_idx] <= 1'b1;
								btn_wr_q[slot_idx]  <= 1'b1;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				ST_DECIDE: begin
					if (armed_q && in_learn) begin
						scan_q  <= '0;
						state_q <= ST_LEARN;
					end else if (free) begin
						if (armed_q) begin
							armed_q <= 1'b0;
							for (int i = 0; i < SLOTS; i++) begin
								if (mode_q[i] == MODE_WAIT) begin
									mode_q[i] <= MODE_OFF;
								end
							end
						end
						if (in_repeat) begin
							last_ev_q <= now_q;
							state_q   <= ST_IDLE;
						end else begin
							scan_q   <= '0;
							cmp_v_s1 <= 1'b0;
							state_q  <= ST_MATCH;
						end
					end
				end
				ST_LEARN: begin
					if (free) begin
						if (!scan_end) begin
							if (learn_hit) begin
								mode_q[idx_scan]    <= MODE_ACTIVE;
								code_wr_q[idx_scan] <= 1'b1;
								armed_q             <= 1'b0;
								last_ev_q           <= now_q;
							end
							scan_q <= scan_q + 1'b1;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_MATCH: begin
					if (free) begin
						if (!scan_end) begin
							cmp_v_s1    <= 1'b1;
							cmp_idx_s1  <= idx_scan;
							code_vld_s1 <= code_wr_q[idx_scan];
							btn_vld_s1  <= btn_wr_q[idx_scan];
							scan_q      <= scan_q + 1'b1;
						end else begin
							cmp_v_s1 <= 1'b0;
						end
						if (match_hit) begin
							last_ev_q <= now_q;
						end
						if (scan_end && !cmp_v_s1) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	rclt_ram #(
		.WIDTH (CODE_W),
		.DEPTH (SLOTS)
	) u_code_ram (
		.clk   (clk),
		.we    (code_we),
		.waddr (code_waddr),
		.wdata (code_q),
		.re    (rd_re),
		.raddr (idx_scan),
		.rdata (code_rdata)
	);

	rclt_ram #(
		.WIDTH (BTN_W),
		.DEPTH (SLOTS)
	) u_btn_ram (
		.clk   (clk),
		.we    (btn_we),
		.waddr (slot_idx),
		.wdata (lbutton_q),
		.re    (rd_re),
		.raddr (idx_scan),
		.rdata (btn_rdata)
	);

	rclt_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res_o),
		.last      (last)
	);

	assign kind     = res_o.kind;
	assign ok       = res_o.ok;
	assign button   = res_o.button;
	assign hit_slot = res_o.hit_slot;

endmodule

>>> design/rclt_checker.sv
// Port-level checks for the remote code learning table core, attached by bind.
// Depends on rclt_pkg and remote_code_learning_table_core.
module rclt_checker #(
	parameter int SLOTS = rclt_pkg::SLOTS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [rclt_pkg::KIND_W-1:0] kind,
	input logic                        ok,
	input logic [rclt_pkg::BTN_W-1:0]  button,
	input logic [rclt_pkg::HIT_W-1:0]  hit_slot,
	input logic                        last
);

	import rclt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(button)
			&& $stable(hit_slot) && $stable(last))
		else $error("output word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready high right after an accepted word");

	a_ok_for_events: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_ACK |-> ok)
		else $error("event word without ok");

	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_ACK || kind == KIND_SUPPRESS || kind == KIND_NOMATCH)
			|-> last)
		else $error("single-word result without last");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_BUTTON || kind == KIND_LEARNED)
			|-> ({1'b0, hit_slot} < (HIT_W + 1)'(SLOTS)))
		else $error("hit slot out of range");

endmodule

bind remote_code_learning_table_core rclt_checker #(
	.SLOTS (SLOTS)
) u_rclt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.ok        (ok),
	.button    (button),
	.hit_slot  (hit_slot),
	.last      (last)
);
